FILE: design/tnh_pkg.sv
// Shared constants, register indexes and the stage payload type of the terrain normal pipeline.
// No dependencies; every other file of the block but tnh_skid refers to it by scoped names.
`timescale 1ns / 1ps

package tnh_pkg;

    localparam int MAX_GRID_SIZE_DEF = 1025;

    localparam int HEIGHT_W  = 32;
    localparam int COORD_W   = 11;
    localparam int SIZE_W    = 11;
    localparam int SPACING_W = 10;
    localparam int NRM_W     = 16;
    localparam int NZ_W      = 15;
    localparam int EXT_W     = 34;
    localparam int MAG_W     = 31;
    localparam int MZ_W      = 27;
    localparam int SQ_W      = 62;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int QUO_W     = 16;
    localparam int NUM_W     = 47;
    localparam int LANES     = 3;

    localparam int IN_DATA_W  = 184;
    localparam int IN_USER_W  = 4;
    localparam int RES_W      = 47;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SPACING = 1'b1;

    localparam logic [SIZE_W-1:0]    GRID_SIZE_RST    = 11'd257;
    localparam logic [SPACING_W-1:0] GRID_SPACING_RST = 10'd1;

    localparam logic [QUO_W-1:0] Q15_MAX = 16'd32767;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] mz;
        logic             neg_x;
        logic             neg_y;
    } comp_t;

endpackage

FILE: design/tnh_prep.sv
// Front stages: edge extrapolation, central differences, and common down-shift of the vector.
// Depends on tnh_pkg.
`timescale 1ns / 1ps

module tnh_prep #(
    parameter int MAX_GRID_SIZE = tnh_pkg::MAX_GRID_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             ce,
    input  logic                             in_valid,
    input  logic [tnh_pkg::HEIGHT_W-1:0]     centre_height,
    input  logic [tnh_pkg::HEIGHT_W-1:0]     left_height,
    input  logic [tnh_pkg::HEIGHT_W-1:0]     right_height,
    input  logic [tnh_pkg::HEIGHT_W-1:0]     down_height,
    input  logic [tnh_pkg::HEIGHT_W-1:0]     up_height,
    input  logic [tnh_pkg::COORD_W-1:0]      column,
    input  logic [tnh_pkg::COORD_W-1:0]      row,
    input  logic                             left_skirt_present,
    input  logic                             right_skirt_present,
    input  logic                             bottom_skirt_present,
    input  logic                             top_skirt_present,
    input  logic [tnh_pkg::SIZE_W-1:0]       grid_size,
    input  logic [tnh_pkg::SPACING_W-1:0]    grid_spacing,
    output logic                             out_valid,
    output tnh_pkg::comp_t                   out_comp
);

    localparam int SZ_BITS = $clog2(MAX_GRID_SIZE + 1);
    localparam int SZ_W    = (SZ_BITS > tnh_pkg::COORD_W) ? SZ_BITS : tnh_pkg::COORD_W;
    localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_GRID_SIZE);
    localparam int W = tnh_pkg::EXT_W;

    // stage A: substitute missing neighbors
    logic [SZ_W-1:0] size_c, last_c;
    logic            first_col, last_col, first_row, last_row;
    logic signed [W-1:0] c_x, c2, l_x, r_x, d_x, u_x;
    logic signed [W-1:0] lv_next, rv_next, dv_next, uv_next;
    logic signed [W-1:0] lv_reg, rv_reg, dv_reg, uv_reg;
    logic                a_valid_reg;

    always_comb begin
        size_c    = (SZ_W'(grid_size) > MAX_SZ) ? MAX_SZ : SZ_W'(grid_size);
        last_c    = size_c - SZ_W'(1);
        first_col = (column == '0);
        first_row = (row == '0);
        last_col  = (size_c == '0) || (SZ_W'(column) >= last_c);
        last_row  = (size_c == '0) || (SZ_W'(row) >= last_c);
        c_x = {{2{centre_height[31]}}, centre_height};
        l_x = {{2{left_height[31]}}, left_height};
        r_x = {{2{right_height[31]}}, right_height};
        d_x = {{2{down_height[31]}}, down_height};
        u_x = {{2{up_height[31]}}, up_height};
        c2  = {c_x[W-2:0], 1'b0};
        lv_next = (first_col && !left_skirt_present)   ? c2 - r_x : l_x;
        rv_next = (last_col  && !right_skirt_present)  ? c2 - l_x : r_x;
        dv_next = (first_row && !bottom_skirt_present) ? c2 - u_x : d_x;
        uv_next = (last_row  && !top_skirt_present)    ? c2 - d_x : u_x;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= in_valid;
        end
        if (ce) begin
            lv_reg <= lv_next;
            rv_reg <= rv_next;
            dv_reg <= dv_next;
            uv_reg <= uv_next;
        end
    end

    // stage B: differences and magnitudes
    logic signed [W:0]   ax, ay;
    logic [W-1:0]        mx_next, my_next, mx_reg, my_reg;
    logic                nx_next, ny_next, nx_reg, ny_reg;
    logic [tnh_pkg::SPACING_W-1:0] sp;
    logic [tnh_pkg::MZ_W-1:0]      mz_next, mz_reg;
    logic                          b_valid_reg;

    always_comb begin
        ax = {lv_reg[W-1], lv_reg} - {rv_reg[W-1], rv_reg};
        ay = {dv_reg[W-1], dv_reg} - {uv_reg[W-1], uv_reg};
        nx_next = ax[W];
        ny_next = ay[W];
        mx_next = nx_next ? W'(-ax) : ax[W-1:0];
        my_next = ny_next ? W'(-ay) : ay[W-1:0];
        sp      = (grid_spacing == '0) ? tnh_pkg::SPACING_W'(1) : grid_spacing;
        mz_next = {sp, 17'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
        if (ce) begin
            mx_reg <= mx_next;
            my_reg <= my_next;
            mz_reg <= mz_next;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
    end

    // stage C: shift all magnitudes until the largest fits 31 bits
    logic [W-1:0]   orv;
    logic [1:0]     sh;
    tnh_pkg::comp_t comp_next, comp_reg;
    logic           c_valid_reg;

    always_comb begin
        orv = mx_reg | my_reg | W'(mz_reg);
        if (orv[33]) begin
            sh = 2'd3;
        end else if (orv[32]) begin
            sh = 2'd2;
        end else if (orv[31]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
        comp_next.mx    = tnh_pkg::MAG_W'(mx_reg >> sh);
        comp_next.my    = tnh_pkg::MAG_W'(my_reg >> sh);
        comp_next.mz    = tnh_pkg::MAG_W'(mz_reg >> sh);
        comp_next.neg_x = nx_reg;
        comp_next.neg_y = ny_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= b_valid_reg;
        end
        if (ce) begin
            comp_reg <= comp_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_comp  = comp_reg;

endmodule

FILE: design/tnh_sqrt.sv
// Squares, sum of squares and a one-bit-per-stage integer square root pipeline.
// Depends on tnh_pkg.
`timescale 1ns / 1ps

module tnh_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  tnh_pkg::comp_t                in_comp,
    output logic                          out_valid,
    output tnh_pkg::comp_t                out_comp,
    output logic [tnh_pkg::ROOT_W-1:0]    out_root
);

    localparam int N  = tnh_pkg::ROOT_W;
    localparam int SW = tnh_pkg::SUM_W;

    // stage D: squares
    logic [tnh_pkg::SQ_W-1:0] sqx_next, sqy_next, sqz_next, sqx_reg, sqy_reg, sqz_reg;
    tnh_pkg::comp_t           d_comp_reg;
    logic                     d_valid_reg;

    always_comb begin
        sqx_next = in_comp.mx * in_comp.mx;
        sqy_next = in_comp.my * in_comp.my;
        sqz_next = in_comp.mz * in_comp.mz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= in_valid;
        end
        if (ce) begin
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            sqz_reg    <= sqz_next;
            d_comp_reg <= in_comp;
        end
    end

    // stage E (index 0) and root stages 1..N
    logic [SW-1:0]  v_reg    [0:N];
    logic [SW-1:0]  res_reg  [0:N];
    tnh_pkg::comp_t comp_reg [0:N];
    logic           valid_reg[0:N];
    logic [SW-1:0]  sum_next;

    assign sum_next = SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= d_valid_reg;
        end
        if (ce) begin
            v_reg[0]    <= sum_next;
            res_reg[0]  <= '0;
            comp_reg[0] <= d_comp_reg;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_root
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - 1 - j));
        logic [SW-1:0] trial;
        logic [SW-1:0] v_next, res_next;

        always_comb begin
            trial = res_reg[j] + BIT;
            if (v_reg[j] >= trial) begin
                v_next   = v_reg[j] - trial;
                res_next = (res_reg[j] >> 1) + BIT;
            end else begin
                v_next   = v_reg[j];
                res_next = res_reg[j] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[j+1] <= valid_reg[j];
            end
            if (ce) begin
                v_reg[j+1]    <= v_next;
                res_reg[j+1]  <= res_next;
                comp_reg[j+1] <= comp_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_comp  = comp_reg[N];
    assign out_root  = res_reg[N][N-1:0];

endmodule

FILE: design/tnh_div.sv
// Rounded divide of each magnitude by the norm, one quotient bit per stage, then Q1.15 format.
// Depends on tnh_pkg.
`timescale 1ns / 1ps

module tnh_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  tnh_pkg::comp_t                in_comp,
    input  logic [tnh_pkg::ROOT_W-1:0]    in_root,
    output logic                          out_valid,
    output logic [tnh_pkg::RES_W-1:0]     out_data
);

    localparam int Q  = tnh_pkg::QUO_W;
    localparam int RW = tnh_pkg::ROOT_W;
    localparam int L  = tnh_pkg::LANES;
    localparam int NW = tnh_pkg::NUM_W;

    logic [RW-1:0] n_reg    [0:Q];
    logic [RW-1:0] rem_reg  [0:Q][L];
    logic [Q-1:0]  low_reg  [0:Q][L];
    logic [Q-1:0]  q_reg    [0:Q][L];
    logic          nx_reg   [0:Q];
    logic          ny_reg   [0:Q];
    logic          valid_reg[0:Q];

    // stage F: numerator = u * 2^15 + n/2
    logic [RW-1:0]           n_next;
    logic [tnh_pkg::MAG_W-1:0] u_in [L];
    logic [NW-1:0]           num [L];

    always_comb begin
        n_next  = (in_root == '0) ? RW'(1) : in_root;
        u_in[0] = in_comp.mx;
        u_in[1] = in_comp.my;
        u_in[2] = in_comp.mz;
        for (int i = 0; i < L; i++) begin
            num[i] = {u_in[i], 15'b0} + NW'(n_next >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= in_valid;
        end
        if (ce) begin
            n_reg[0]  <= n_next;
            nx_reg[0] <= in_comp.neg_x;
            ny_reg[0] <= in_comp.neg_y;
            for (int i = 0; i < L; i++) begin
                rem_reg[0][i] <= RW'(num[i][NW-1:Q]);
                low_reg[0][i] <= num[i][Q-1:0];
                q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar s = 0; s < Q; s++) begin : g_div
        localparam int B = Q - 1 - s;
        logic [RW:0]   t       [L];
        logic          ge      [L];
        logic [RW-1:0] rem_next[L];
        logic [Q-1:0]  q_next  [L];

        always_comb begin
            for (int i = 0; i < L; i++) begin
                t[i]        = {rem_reg[s][i], low_reg[s][i][B]};
                ge[i]       = (t[i] >= {1'b0, n_reg[s]});
                rem_next[i] = ge[i] ? RW'(t[i] - {1'b0, n_reg[s]}) : t[i][RW-1:0];
                q_next[i]   = q_reg[s][i] | (Q'(ge[i]) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[s+1] <= valid_reg[s];
            end
            if (ce) begin
                n_reg[s+1]  <= n_reg[s];
                nx_reg[s+1] <= nx_reg[s];
                ny_reg[s+1] <= ny_reg[s];
                for (int i = 0; i < L; i++) begin
                    rem_reg[s+1][i] <= rem_next[i];
                    low_reg[s+1][i] <= low_reg[s][i];
                    q_reg[s+1][i]   <= q_next[i];
                end
            end
        end
    end

    // saturate and restore sign
    logic [Q-1:0]             mag [L];
    logic [tnh_pkg::NRM_W-1:0] nrm_x, nrm_y;
    logic [tnh_pkg::NZ_W-1:0]  nrm_z;

    always_comb begin
        for (int i = 0; i < L; i++) begin
            mag[i] = (q_reg[Q][i] > tnh_pkg::Q15_MAX) ? tnh_pkg::Q15_MAX : q_reg[Q][i];
        end
        nrm_x = nx_reg[Q] ? (Q'(0) - mag[0]) : mag[0];
        nrm_y = ny_reg[Q] ? (Q'(0) - mag[1]) : mag[1];
        nrm_z = mag[2][tnh_pkg::NZ_W-1:0];
    end

    assign out_valid = valid_reg[Q];
    assign out_data  = {nrm_z, nrm_y, nrm_x};

endmodule

FILE: design/tnh_skid.sv
// Output register with one spare entry; its registered ready drives the pipeline enable.
// Depends on tnh_pkg for nothing but is sized by its DATA_W parameter.
`timescale 1ns / 1ps

module tnh_skid #(
    parameter int DATA_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output logic              in_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              spare_valid_reg, spare_valid_next;
    logic [DATA_W-1:0] spare_data_reg, spare_data_next;
    logic              in_fire;

    always_comb begin
        in_fire          = in_valid && !spare_valid_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        spare_valid_next = spare_valid_reg;
        spare_data_next  = spare_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (spare_valid_reg) begin
                out_valid_next   = 1'b1;
                out_data_next    = spare_data_reg;
                spare_valid_next = 1'b0;
            end else begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end else if (in_fire) begin
            spare_valid_next = 1'b1;
            spare_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
        out_data_reg   <= out_data_next;
        spare_data_reg <= spare_data_next;
    end

    assign in_ready = !spare_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: design/terrain_normal_from_heights.sv
// Top level of the terrain normal pipeline: config registers, stream ports, stage wiring.
// Depends on tnh_pkg, tnh_prep, tnh_sqrt, tnh_div and tnh_skid.
`timescale 1ns / 1ps

// Takes one grid cell per clock while s_tready is high and returns its unit normal in Q1.15,
// in order, one result per request. A request passes 3 front stages, 2 stages of squares and
// sum, 32 square root stages (one root bit each), 17 divide stages (a numerator stage, then one
// quotient bit in each of the other 16) and the output register. The whole pipeline moves on
// one enable taken from the output stage's spare entry, so bubbles close up while the output is
// held and requests are still accepted after the output stalls until the spare entry fills.
// Write grid_size and grid_spacing only while no request is in flight.

module terrain_normal_from_heights #(
    parameter int MAX_GRID_SIZE = tnh_pkg::MAX_GRID_SIZE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // centre_height, left_height, right_height, down_height, up_height, column, row, pad
    input  logic [tnh_pkg::IN_DATA_W-1:0]      s_tdata,
    // left_skirt_present, right_skirt_present, bottom_skirt_present, top_skirt_present
    input  logic [tnh_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // normal_x, normal_y, normal_z, pad
    output logic [tnh_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_wen,
    input  logic [tnh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tnh_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [tnh_pkg::SIZE_W-1:0]    grid_size_reg, grid_size_next;
    logic [tnh_pkg::SPACING_W-1:0] grid_spacing_reg, grid_spacing_next;

    always_comb begin
        grid_size_next    = grid_size_reg;
        grid_spacing_next = grid_spacing_reg;
        if (cfg_wen) begin
            unique case (cfg_index)
                tnh_pkg::REG_GRID_SIZE:
                    grid_size_next = cfg_wdata[tnh_pkg::SIZE_W-1:0];
                tnh_pkg::REG_GRID_SPACING:
                    grid_spacing_next = cfg_wdata[tnh_pkg::SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg    <= tnh_pkg::GRID_SIZE_RST;
            grid_spacing_reg <= tnh_pkg::GRID_SPACING_RST;
        end else begin
            grid_size_reg    <= grid_size_next;
            grid_spacing_reg <= grid_spacing_next;
        end
    end

    logic ce;
    logic in_valid;

    assign s_tready = ce && aresetn;
    assign in_valid = s_tvalid && ce;

    logic                             prep_valid;
    tnh_pkg::comp_t                   prep_comp;
    logic                             sqrt_valid;
    tnh_pkg::comp_t                   sqrt_comp;
    logic [tnh_pkg::ROOT_W-1:0]       sqrt_root;
    logic                             div_valid;
    logic [tnh_pkg::RES_W-1:0]        div_data;

    tnh_prep #(
        .MAX_GRID_SIZE(MAX_GRID_SIZE)
    ) u_prep (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .ce                  (ce),
        .in_valid            (in_valid),
        .centre_height       (s_tdata[31:0]),
        .left_height         (s_tdata[63:32]),
        .right_height        (s_tdata[95:64]),
        .down_height         (s_tdata[127:96]),
        .up_height           (s_tdata[159:128]),
        .column              (s_tdata[170:160]),
        .row                 (s_tdata[181:171]),
        .left_skirt_present  (s_tuser[0]),
        .right_skirt_present (s_tuser[1]),
        .bottom_skirt_present(s_tuser[2]),
        .top_skirt_present   (s_tuser[3]),
        .grid_size           (grid_size_reg),
        .grid_spacing        (grid_spacing_reg),
        .out_valid           (prep_valid),
        .out_comp            (prep_comp)
    );

    tnh_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (prep_valid),
        .in_comp  (prep_comp),
        .out_valid(sqrt_valid),
        .out_comp (sqrt_comp),
        .out_root (sqrt_root)
    );

    tnh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (sqrt_valid),
        .in_comp  (sqrt_comp),
        .in_root  (sqrt_root),
        .out_valid(div_valid),
        .out_data (div_data)
    );

    tnh_skid #(
        .DATA_W(tnh_pkg::OUT_DATA_W)
    ) u_skid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(div_valid),
        .in_data ({1'b0, div_data}),
        .in_ready(ce),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
